>>> rtl/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types and constants of the humidity sensor poll sequencer.
// ----------------------------------------------------------------------------
package hsps_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_DELAY    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKEUP_DELAY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_DELAY = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_CMD     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WAKEUP_CMD    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_CMD   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_ADDR      = 4'd7;

    // register reset values
    localparam logic [31:0] RST_INIT_DELAY    = 32'd1;
    localparam logic [31:0] RST_WAKEUP_DELAY  = 32'd1;
    localparam logic [31:0] RST_MEASURE_DELAY = 32'd13;
    localparam logic [31:0] RST_UPDATE_PERIOD = 32'd1000;
    localparam logic [15:0] RST_SLEEP_CMD     = 16'd45208;
    localparam logic [15:0] RST_WAKEUP_CMD    = 16'd13591;
    localparam logic [15:0] RST_MEASURE_CMD   = 16'd30822;
    localparam logic [6:0]  RST_BUS_ADDR      = 7'd112;

    // request kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_POLL   = 2'd1;
    localparam logic [1:0] KIND_SET_EN = 2'd2;

    // bus actions
    localparam logic [1:0] ACT_BUS_INIT = 2'd0;
    localparam logic [1:0] ACT_WRITE    = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_DEINIT   = 2'd3;

    // conversion constants
    localparam logic [26:0] TEMP_SPAN = 27'd1750;
    localparam logic [11:0] TEMP_BIAS = 12'd450;
    localparam logic [25:0] HUM_SPAN  = 26'd1000;

    typedef struct packed {
        logic [31:0] init_delay;
        logic [31:0] wakeup_delay;
        logic [31:0] measure_delay;
        logic [31:0] update_period;
        logic [15:0] sleep_command;
        logic [15:0] wakeup_command;
        logic [15:0] measure_command;
        logic [6:0]  bus_address;
    } t_cfg;

    // action sequence a poll hands to the back end
    typedef enum logic [2:0] {
        SEQ_INIT_OFF,
        SEQ_INIT_ON,
        SEQ_START,
        SEQ_MEASURE,
        SEQ_READ
    } t_seq;

    typedef struct packed {
        t_seq               seq;
        logic signed [11:0] temp;
        logic [9:0]         hum;
    } t_job;

endpackage

>>> rtl/hsps_in_if.sv
// ----------------------------------------------------------------------------
// hsps_in_if
// Request channel of the poll sequencer.
// ----------------------------------------------------------------------------
interface hsps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] tick_period;
    logic        enable_level;
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;

    modport source (output valid, kind, tick_period, enable_level,
                    raw_temperature, raw_humidity, input ready);
    modport sink   (input valid, kind, tick_period, enable_level,
                    raw_temperature, raw_humidity, output ready);
endinterface

>>> rtl/hsps_out_if.sv
// ----------------------------------------------------------------------------
// hsps_out_if
// Bus action channel of the poll sequencer.
// ----------------------------------------------------------------------------
interface hsps_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [6:0]         device_address;
    logic [15:0]        command_word;
    logic signed [11:0] temperature_tenths;
    logic [9:0]         humidity_tenths;
    logic               update_event;
    logic               last;

    modport source (output valid, action, device_address, command_word,
                    temperature_tenths, humidity_tenths, update_event, last,
                    input ready);
    modport sink   (input valid, action, device_address, command_word,
                    temperature_tenths, humidity_tenths, update_event, last,
                    output ready);
endinterface

>>> rtl/hsps_queue.sv
// ----------------------------------------------------------------------------
// hsps_queue
// Small job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hsps_queue #(
    parameter int DEPTH = hsps_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsps_pkg::t_job  i_job,
    input  logic            i_pop,
    output hsps_pkg::t_job  o_head,
    output logic            o_nonempty,
    output logic            o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hsps_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_full     = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

>>> rtl/hsps_front.sv
// ----------------------------------------------------------------------------
// hsps_front
// Takes requests, keeps phase, timer, enable and readings, queues action jobs.
// ----------------------------------------------------------------------------
module hsps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hsps_pkg::t_cfg  i_cfg,
    hsps_in_if.sink         i_req,
    input  logic            i_q_full,
    output logic            o_push,
    output hsps_pkg::t_job  o_job
);
    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_INIT    = 3'd1,
        PH_START   = 3'd2,
        PH_MEASURE = 3'd3,
        PH_READ    = 3'd4
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_enable, n_enable;
    logic [31:0]        r_count, n_count;
    logic signed [11:0] r_temp, n_temp;
    logic [9:0]         r_hum, n_hum;

    logic        accept;
    logic [26:0] temp_prod;
    logic [25:0] hum_prod;
    logic [32:0] delay_sum;
    logic [32:0] period_ext;
    logic [32:0] reload_diff;
    logic [31:0] reload;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;

    assign temp_prod   = hsps_pkg::TEMP_SPAN * 27'(i_req.raw_temperature);
    assign hum_prod    = hsps_pkg::HUM_SPAN * 26'(i_req.raw_humidity);
    assign delay_sum   = 33'(i_cfg.measure_delay) + 33'(i_cfg.wakeup_delay);
    assign period_ext  = {1'b0, i_cfg.update_period};
    assign reload_diff = period_ext - delay_sum;
    assign reload      = (period_ext > delay_sum) ? reload_diff[31:0] : '0;

    always_comb begin
        n_phase   = r_phase;
        n_enable  = r_enable;
        n_count   = r_count;
        n_temp    = r_temp;
        n_hum     = r_hum;
        o_push    = 1'b0;
        o_job.seq = hsps_pkg::SEQ_START;
        if (accept) begin
            unique case (i_req.kind)
                hsps_pkg::KIND_TICK: begin
                    n_count = (r_count > i_req.tick_period)
                            ? r_count - i_req.tick_period : '0;
                end
                hsps_pkg::KIND_SET_EN: begin
                    n_enable = i_req.enable_level;
                end
                hsps_pkg::KIND_POLL: begin
                    if (r_count == '0) begin
                        unique case (r_phase)
                            PH_OFF: begin
                                if (r_enable) begin
                                    n_count = i_cfg.init_delay;
                                    n_phase = PH_START;
                                end
                            end
                            PH_INIT: begin
                                o_push = 1'b1;
                                if (r_enable) begin
                                    n_count   = i_cfg.init_delay;
                                    n_phase   = PH_START;
                                    o_job.seq = hsps_pkg::SEQ_INIT_ON;
                                end else begin
                                    n_phase   = PH_OFF;
                                    o_job.seq = hsps_pkg::SEQ_INIT_OFF;
                                end
                            end
                            PH_START: begin
                                o_push    = 1'b1;
                                n_count   = i_cfg.wakeup_delay;
                                n_phase   = PH_MEASURE;
                                o_job.seq = hsps_pkg::SEQ_START;
                            end
                            PH_MEASURE: begin
                                o_push    = 1'b1;
                                n_count   = i_cfg.measure_delay;
                                n_phase   = PH_READ;
                                o_job.seq = hsps_pkg::SEQ_MEASURE;
                            end
                            PH_READ: begin
                                o_push    = 1'b1;
                                o_job.seq = hsps_pkg::SEQ_READ;
                                if (r_enable) begin
                                    n_count = reload;
                                    n_phase = PH_START;
                                end else begin
                                    n_phase = PH_OFF;
                                end
                                n_temp = $signed({1'b0, temp_prod[26:16]})
                                       - $signed(hsps_pkg::TEMP_BIAS);
                                n_hum  = hum_prod[25:16];
                            end
                            default: begin
                                n_phase = PH_INIT;
                                n_count = '0;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
        // readings after this request's update travel with the job
        o_job.temp = n_temp;
        o_job.hum  = n_hum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_INIT;
            r_enable <= 1'b0;
            r_count  <= hsps_pkg::RST_INIT_DELAY;
            r_temp   <= '0;
            r_hum    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_enable <= n_enable;
            r_count  <= n_count;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
        end
    end
endmodule

>>> rtl/hsps_back.sv
// ----------------------------------------------------------------------------
// hsps_back
// Turns jobs into bus actions in an output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module hsps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hsps_pkg::t_cfg  i_cfg,
    input  hsps_pkg::t_job  i_head,
    input  logic            i_nonempty,
    output logic            o_pop,
    hsps_out_if.source      o_rsp
);
    logic [1:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic       load;

    logic [1:0]  act;
    logic [15:0] cmd;
    logic        fin;
    logic        upd;

    logic [1:0]         r_action;
    logic [6:0]         r_addr;
    logic [15:0]        r_cmd;
    logic signed [11:0] r_temp;
    logic [9:0]         r_hum;
    logic               r_upd;
    logic               r_last;

    assign load  = i_nonempty && (!r_valid || o_rsp.ready);
    assign o_pop = load && fin;

    // action table per job and step
    always_comb begin
        act = hsps_pkg::ACT_BUS_INIT;
        cmd = '0;
        fin = 1'b0;
        upd = 1'b0;
        unique case (i_head.seq)
            hsps_pkg::SEQ_INIT_OFF, hsps_pkg::SEQ_INIT_ON: begin
                unique case (r_step)
                    2'd0: act = hsps_pkg::ACT_BUS_INIT;
                    2'd1: begin
                        act = hsps_pkg::ACT_WRITE;
                        cmd = i_cfg.sleep_command;
                        fin = (i_head.seq == hsps_pkg::SEQ_INIT_ON);
                    end
                    default: begin
                        act = hsps_pkg::ACT_DEINIT;
                        fin = 1'b1;
                    end
                endcase
            end
            hsps_pkg::SEQ_START: begin
                if (r_step == 2'd0) begin
                    act = hsps_pkg::ACT_BUS_INIT;
                end else begin
                    act = hsps_pkg::ACT_WRITE;
                    cmd = i_cfg.wakeup_command;
                    fin = 1'b1;
                end
            end
            hsps_pkg::SEQ_MEASURE: begin
                act = hsps_pkg::ACT_WRITE;
                cmd = i_cfg.measure_command;
                fin = 1'b1;
            end
            hsps_pkg::SEQ_READ: begin
                unique case (r_step)
                    2'd0: act = hsps_pkg::ACT_READ;
                    2'd1: begin
                        act = hsps_pkg::ACT_WRITE;
                        cmd = i_cfg.sleep_command;
                    end
                    default: begin
                        act = hsps_pkg::ACT_DEINIT;
                        fin = 1'b1;
                        upd = 1'b1;
                    end
                endcase
            end
            default: fin = 1'b1;
        endcase
    end

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_step  = fin ? 2'd0 : r_step + 2'd1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_action <= act;
            r_addr   <= i_cfg.bus_address;
            r_cmd    <= cmd;
            r_temp   <= i_head.temp;
            r_hum    <= i_head.hum;
            r_upd    <= upd;
            r_last   <= fin;
        end
    end

    assign o_rsp.valid              = r_valid;
    assign o_rsp.action             = r_action;
    assign o_rsp.device_address     = r_addr;
    assign o_rsp.command_word       = r_cmd;
    assign o_rsp.temperature_tenths = r_temp;
    assign o_rsp.humidity_tenths    = r_hum;
    assign o_rsp.update_event       = r_upd;
    assign o_rsp.last               = r_last;
endmodule

>>> rtl/humidity_sensor_poll_sequencer_core.sv
// ----------------------------------------------------------------------------
// humidity_sensor_poll_sequencer_core
// Poll sequencer for a two-wire temperature and humidity sensor.
// ----------------------------------------------------------------------------
// i_req carries tick, poll and set-enable requests. ticks count the timer
// down, set-enable stores the enable flag, a poll with the timer at zero
// advances the phase and yields up to three bus actions on o_rsp; the last
// action of a request has last set, a read marks it with update_event.
// configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// by the user only while the block is idle, not enforced by the block;
// indexes past the register list are ignored. every request is taken as long
// as the two-entry job queue has room; the first action of a poll passes the
// job queue and the output register on its way to o_rsp, later actions follow
// one per cycle while o_rsp is ready; that port sets sustained throughput.
// when o_rsp stalls, the output register holds, the queue fills and then
// i_req.ready drops. synchronous reset puts the phase at init, the timer at
// the init delay, clears the enable flag, readings and queue, and loads the
// register reset values.
// ----------------------------------------------------------------------------
module humidity_sensor_poll_sequencer_core #(
    parameter int QUEUE_DEPTH = hsps_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hsps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hsps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hsps_in_if.sink                         i_req,
    hsps_out_if.source                      o_rsp
);
    hsps_pkg::t_cfg r_cfg;
    hsps_pkg::t_job push_job, head_job;
    logic push, pop, q_nonempty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_delay      <= hsps_pkg::RST_INIT_DELAY;
            r_cfg.wakeup_delay    <= hsps_pkg::RST_WAKEUP_DELAY;
            r_cfg.measure_delay   <= hsps_pkg::RST_MEASURE_DELAY;
            r_cfg.update_period   <= hsps_pkg::RST_UPDATE_PERIOD;
            r_cfg.sleep_command   <= hsps_pkg::RST_SLEEP_CMD;
            r_cfg.wakeup_command  <= hsps_pkg::RST_WAKEUP_CMD;
            r_cfg.measure_command <= hsps_pkg::RST_MEASURE_CMD;
            r_cfg.bus_address     <= hsps_pkg::RST_BUS_ADDR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsps_pkg::REG_INIT_DELAY:    r_cfg.init_delay    <= i_cfg_data;
                hsps_pkg::REG_WAKEUP_DELAY:  r_cfg.wakeup_delay  <= i_cfg_data;
                hsps_pkg::REG_MEASURE_DELAY: r_cfg.measure_delay <= i_cfg_data;
                hsps_pkg::REG_UPDATE_PERIOD: r_cfg.update_period <= i_cfg_data;
                hsps_pkg::REG_SLEEP_CMD:     r_cfg.sleep_command <= i_cfg_data[15:0];
                hsps_pkg::REG_WAKEUP_CMD:    r_cfg.wakeup_command <= i_cfg_data[15:0];
                hsps_pkg::REG_MEASURE_CMD:   r_cfg.measure_command <= i_cfg_data[15:0];
                hsps_pkg::REG_BUS_ADDR:      r_cfg.bus_address <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    hsps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    hsps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    hsps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (head_job),
        .i_nonempty (q_nonempty),
        .o_pop      (pop),
        .o_rsp      (o_rsp)
    );
endmodule
